// ----- hdl/datp_pkg.sv -----
// ----------------------------------------------------------------------------
// datp_pkg
// Shared types, character codes and status codes of the decimal ARGB parser.
// ----------------------------------------------------------------------------
`default_nettype none

package datp_pkg;

  localparam int POSITION_LIMIT_DEF = 255;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // character classes
  localparam logic [2:0] CLS_DIGIT = 3'd0;
  localparam logic [2:0] CLS_SPACE = 3'd1;
  localparam logic [2:0] CLS_SIGN  = 3'd2;
  localparam logic [2:0] CLS_COMMA = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_COMMA = 2'd2;

  typedef struct packed {
    logic       start_req;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] argb;
    logic [1:0]  status;
    logic [7:0]  consumed_length;
  } out_word_t;

  // classified character handed from front to back
  typedef struct packed {
    logic       start;
    logic [2:0] cls;
    logic [3:0] val;   // digit value, or bit 0 set for a minus sign
  } cls_word_t;

endpackage

`default_nettype wire

// ----- hdl/decimal_argb_text_parser_unit.sv -----
// ----------------------------------------------------------------------------
// decimal_argb_text_parser_unit
// Parses four comma-separated decimal numbers from a character stream into a
// packed ARGB word.
//
//   channel   ports                       direction   word
//   input     in_push in_full in_data     in          start_req, char_byte
//   result    out_pop out_empty out_data  out         argb, status, length
//
// One character per cycle is taken; a character is classified on entry, waits
// in a four-entry queue and is parsed from the head of that queue.
// A result is visible on out_data in the cycle after its closing character is
// parsed and waits in a two-entry result queue.
// The parser stalls only while both result entries are taken; the input then
// stalls once the character queue has filled. Synchronous reset empties both
// queues and leaves the parser idle until a start character.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_argb_text_parser_unit #(
  parameter int POSITION_LIMIT = datp_pkg::POSITION_LIMIT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire datp_pkg::in_word_t  in_data,
  output logic                     in_full,
  input  wire logic                out_pop,
  output datp_pkg::out_word_t      out_data,
  output logic                     out_empty
);

  import datp_pkg::*;

  localparam int CLS_W = $bits(cls_word_t);
  localparam int RES_W = $bits(out_word_t);

  logic      cq_full, cq_empty, cq_wr, cq_rd;
  cls_word_t cq_wdata, cq_rdata;
  logic      rq_full, rq_wr;
  out_word_t rq_wdata;

  datp_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (cq_full),
    .q_wr    (cq_wr),
    .q_data  (cq_wdata)
  );

  datp_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (4)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_wr),
    .wr_data (cq_wdata),
    .full    (cq_full),
    .rd_en   (cq_rd),
    .rd_data (cq_rdata),
    .empty   (cq_empty)
  );

  datp_back #(
    .POSITION_LIMIT (POSITION_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (cq_empty),
    .q_data   (cq_rdata),
    .q_rd     (cq_rd),
    .res_full (rq_full),
    .res_wr   (rq_wr),
    .res_data (rq_wdata)
  );

  datp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_wr),
    .wr_data (rq_wdata),
    .full    (rq_full),
    .rd_en   (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

// ----- hdl/datp_fifo.sv -----
// ----------------------------------------------------------------------------
// datp_fifo
// Small register-based queue with a combinational head read.
// ----------------------------------------------------------------------------
`default_nettype none

module datp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/datp_front.sv -----
// ----------------------------------------------------------------------------
// datp_front
// Accepts input words and sorts each character into a class for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module datp_front (
  input  wire logic               in_push,
  input  wire datp_pkg::in_word_t in_data,
  output logic                    in_full,
  input  wire logic               q_full,
  output logic                    q_wr,
  output datp_pkg::cls_word_t     q_data
);

  import datp_pkg::*;

  logic [7:0] c;

  assign c       = in_data.char_byte;
  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;

  always_comb begin
    q_data.start = in_data.start_req;
    q_data.val   = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      q_data.cls = CLS_DIGIT;
      q_data.val = 4'(c - CHAR_ZERO);
    end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
      q_data.cls = CLS_SPACE;
    end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
      q_data.cls = CLS_SIGN;
      q_data.val = {3'b000, c == CHAR_MINUS};
    end else if (c == CHAR_COMMA) begin
      q_data.cls = CLS_COMMA;
    end else begin
      q_data.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/datp_back.sv -----
// ----------------------------------------------------------------------------
// datp_back
// Parse state: accumulates numbers, packs fields and issues the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module datp_back #(
  parameter int POSITION_LIMIT = datp_pkg::POSITION_LIMIT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire datp_pkg::cls_word_t q_data,
  output logic                     q_rd,
  input  wire logic                res_full,
  output logic                     res_wr,
  output datp_pkg::out_word_t      res_data
);

  import datp_pkg::*;

  localparam int PW = $clog2(POSITION_LIMIT + 1);

  logic          active_r, active_nxt;
  logic          in_digits_r, in_digits_nxt;
  logic [1:0]    field_r, field_nxt;
  logic          neg_r, neg_nxt;
  logic [8:0]    acc_r, acc_nxt;
  logic [23:0]   packed_r, packed_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  // values after a start marker has been applied
  logic          act_e, dig_e, neg_e;
  logic [1:0]    field_e;
  logic [8:0]    acc_e;
  logic [23:0]   packed_e;
  logic [PW-1:0] pos_e, pos_inc;
  logic [11:0]   acc_mac;
  logic [16:0]   pos_ext;

  assign q_rd = !q_empty && !res_full;

  always_comb begin
    act_e    = active_r;
    dig_e    = in_digits_r;
    neg_e    = neg_r;
    field_e  = field_r;
    acc_e    = acc_r;
    packed_e = packed_r;
    pos_e    = pos_r;
    if (q_data.start) begin
      act_e    = 1'b1;
      dig_e    = 1'b0;
      neg_e    = 1'b0;
      field_e  = '0;
      acc_e    = '0;
      packed_e = '0;
      pos_e    = '0;
    end
  end

  assign acc_mac = 12'(acc_e) * 12'd10 + 12'(q_data.val);
  assign pos_inc = (pos_e < PW'(POSITION_LIMIT)) ? pos_e + 1'b1 : pos_e;
  assign pos_ext = {{(17 - PW){1'b0}}, pos_e};

  always_comb begin
    active_nxt    = active_r;
    in_digits_nxt = in_digits_r;
    neg_nxt       = neg_r;
    field_nxt     = field_r;
    acc_nxt       = acc_r;
    packed_nxt    = packed_r;
    pos_nxt       = pos_r;
    res_wr        = 1'b0;
    res_data.argb            = '0;
    res_data.status          = ST_OK;
    res_data.consumed_length = '0;
    if (q_rd) begin
      active_nxt    = act_e;
      in_digits_nxt = dig_e;
      neg_nxt       = neg_e;
      field_nxt     = field_e;
      acc_nxt       = acc_e;
      packed_nxt    = packed_e;
      pos_nxt       = pos_e;
      if (act_e) begin
        if (q_data.cls == CLS_DIGIT) begin
          acc_nxt       = (acc_mac > 12'd256) ? 9'd256 : acc_mac[8:0];
          in_digits_nxt = 1'b1;
          pos_nxt       = pos_inc;
        end else if (!dig_e && q_data.cls == CLS_SPACE) begin
          pos_nxt = pos_inc;
        end else if (!dig_e && q_data.cls == CLS_SIGN) begin
          neg_nxt       = q_data.val[0];
          in_digits_nxt = 1'b1;
          pos_nxt       = pos_inc;
        end else if (acc_e > 9'd255 || (neg_e && acc_e != '0)) begin
          res_wr          = 1'b1;
          res_data.status = ST_RANGE;
          active_nxt      = 1'b0;
        end else if (field_e == 2'd3) begin
          res_wr                   = 1'b1;
          res_data.argb            = {packed_e, acc_e[7:0]};
          res_data.consumed_length = (pos_ext > 17'd255) ? 8'hFF : pos_ext[7:0];
          active_nxt               = 1'b0;
        end else if (q_data.cls != CLS_COMMA) begin
          res_wr          = 1'b1;
          res_data.status = ST_COMMA;
          active_nxt      = 1'b0;
        end else begin
          // field done, start the next number
          packed_nxt    = {packed_e[15:0], acc_e[7:0]};
          field_nxt     = field_e + 1'b1;
          pos_nxt       = pos_inc;
          in_digits_nxt = 1'b0;
          neg_nxt       = 1'b0;
          acc_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      in_digits_r <= 1'b0;
      neg_r       <= 1'b0;
      field_r     <= '0;
      acc_r       <= '0;
      packed_r    <= '0;
      pos_r       <= '0;
    end else begin
      active_r    <= active_nxt;
      in_digits_r <= in_digits_nxt;
      neg_r       <= neg_nxt;
      field_r     <= field_nxt;
      acc_r       <= acc_nxt;
      packed_r    <= packed_nxt;
      pos_r       <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the decimal ARGB text parser. Character streams are fed through the
// input queue, and a mirror of the parser predicts each result word. Results
// are compared field by field as they are popped. The stimulus is short
// directed strings for each corner of the number syntax, followed by random
// records. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import datp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 370;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_word_t  in_data = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  out_word_t out_data;
  logic      out_empty;

  decimal_argb_text_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_data (out_data),
    .out_empty(out_empty)
  );

  int         err_cnt = 0;
  int         idle_cycles = 0;
  int         item_cnt = 0;
  int         burst_left = 0;
  int         gap_max = 0;
  logic [9:0] pop_phase = '0;

  // result words still owed by the parser, oldest first
  out_word_t  argb_due_q[$];
  logic [7:0] rec_q[$];

  // mirror of the parser state
  logic        m_active;
  logic        m_in_digits;
  logic        m_negative;
  logic [1:0]  m_field;
  logic [8:0]  m_acc;
  logic [23:0] m_packed;
  logic [7:0]  m_pos;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic void bump_pos();
    if (m_pos < POSITION_LIMIT_DEF) m_pos++;
  endfunction

  function automatic void clear_number();
    m_in_digits = 1'b0;
    m_negative  = 1'b0;
    m_acc       = '0;
  endfunction

  function automatic void note_result(logic [31:0] argb, logic [1:0] st, logic [7:0] len);
    out_word_t r;
    r.argb            = argb;
    r.status          = st;
    r.consumed_length = len;
    argb_due_q.push_back(r);
    m_active = 1'b0;
  endfunction

  function automatic void parse_char(in_word_t w);
    int         acc_next;
    logic [7:0] c;
    c = w.char_byte;
    if (w.start_req) begin
      m_active = 1'b1;
      m_field  = '0;
      m_packed = '0;
      m_pos    = '0;
      clear_number();
    end
    if (!m_active) return;
    if (is_digit(c)) begin
      acc_next = int'(m_acc) * 10 + int'(c) - int'(CHAR_ZERO);
      if (acc_next > 256) acc_next = 256;
      m_acc       = acc_next[8:0];
      m_in_digits = 1'b1;
      bump_pos();
      return;
    end
    if (!m_in_digits) begin
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
        bump_pos();
        return;
      end
      if (c == CHAR_MINUS || c == CHAR_PLUS) begin
        m_negative  = (c == CHAR_MINUS);
        m_in_digits = 1'b1;
        bump_pos();
        return;
      end
    end
    // this character closes the current number
    if (m_acc > 9'd255 || (m_negative && m_acc != 0))
      note_result('0, ST_RANGE, '0);
    else if (m_field == 2'd3)
      note_result({m_packed, m_acc[7:0]}, ST_OK, m_pos);
    else if (c != CHAR_COMMA)
      note_result('0, ST_COMMA, '0);
    else begin
      m_packed = {m_packed[15:0], m_acc[7:0]};
      m_field++;
      bump_pos();
      clear_number();
    end
  endfunction

  function automatic logic [7:0] any_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c));
    return c;
  endfunction

  task automatic send_char(input logic start, input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= {start, c};
    do @(posedge clk); while (in_full);
    if (start || m_active) item_cnt++;
    parse_char({start, c});
    burst_left--;
  endtask

  task automatic send_text(input string s, input bit fresh = 1'b1);
    for (int i = 0; i < s.len(); i++) send_char(fresh && i == 0, s[i]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (argb_due_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // fills rec_q with one four-field record, mostly well formed
  function automatic void fill_record();
    int    sgn, r, val, k;
    string digits;
    rec_q.delete();
    for (int f = 0; f < 4; f++) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(8, 13);
          rec_q.push_back(k == 8 ? CHAR_SPACE : 8'(k));
        end
      end
      sgn = $urandom_range(0, 5);
      if (sgn == 0) rec_q.push_back(CHAR_MINUS);
      if (sgn == 1) rec_q.push_back(CHAR_PLUS);
      r = $urandom_range(0, 19);
      if (r == 0) val = -1;
      else if (r < 3) val = $urandom_range(256, 999);
      else if (sgn == 0 && r < 15) val = 0;
      else val = $urandom_range(0, 255);
      if (val >= 0) begin
        if ($urandom_range(0, 4) == 0) rec_q.push_back(CHAR_ZERO);
        digits = $sformatf("%0d", val);
        for (int i = 0; i < digits.len(); i++) rec_q.push_back(digits[i]);
      end
      if (f < 3 && $urandom_range(0, 15) != 0) rec_q.push_back(CHAR_COMMA);
      else rec_q.push_back(any_non_digit());
    end
  endfunction

  task automatic test_valid_fields();
    gap_max = 0;
    send_text("255,0,128,7;");
    send_text(" \t+012,-0,\r-,9 ");
    send_text(",,,;");
    drain();
  endtask

  task automatic test_range_errors();
    gap_max = 3;
    send_text("256,1");
    send_text("99999;");
    send_text("-5,");
    send_text("7,8,9,-1;");
    drain();
  endtask

  task automatic test_missing_comma();
    gap_max = 2;
    send_text("1,2;3");
    send_text("1+,");
    send_text("+-");
    send_text("4,5,6 7");
    drain();
  endtask

  task automatic test_fourth_terminator();
    gap_max = 0;
    send_text("1,2,3,4,");
    send_text("10,20,30,40");
    send_char(1'b0, 8'h00);
    drain();
  endtask

  task automatic test_restart_and_idle();
    gap_max = 4;
    send_char(1'b0, "a");
    send_text("12,3");
    send_text("5,6,7,8x");
    send_char(1'b0, "9");
    drain();
  endtask

  task automatic test_long_position();
    gap_max = 0;
    send_char(1'b1, CHAR_SPACE);
    repeat (269) send_char(1'b0, CHAR_SPACE);
    send_text("1,2,3,4;", 1'b0);
    drain();
  endtask

  task automatic test_random_records();
    int kind, n;
    item_cnt = 0;
    while (item_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 2;
        default: gap_max = 8;
      endcase
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // raw byte noise, with stray restarts
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          send_char(i == 0 || $urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
      end else begin
        fill_record();
        // cut short so that the next record restarts mid-parse
        n = (kind == 1) ? $urandom_range(1, rec_q.size()) : rec_q.size();
        for (int i = 0; i < n; i++) send_char(i == 0, rec_q[i]);
        if (kind == 2) send_char(1'b0, 8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  // receiver stall pattern, switching style as pop_phase[9:8] advances
  always @(negedge clk) begin
    pop_phase <= pop_phase + 1'b1;
    case (pop_phase[9:8])
      2'd0: out_pop <= 1'b1;
      2'd1: out_pop <= ($urandom_range(0, 3) != 0);
      2'd2: out_pop <= (pop_phase[4:0] < 5'd20);
      default: out_pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    out_word_t due;
    if (rst_n && out_pop && !out_empty) begin
      if (argb_due_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word argb=%h status=%0d length=%0d", $time,
                 out_data.argb, out_data.status, out_data.consumed_length);
      end else begin
        due = argb_due_q.pop_front();
        if (out_data.argb !== due.argb) begin
          err_cnt++;
          $display("%0t: argb expected %h actual %h", $time, due.argb, out_data.argb);
        end
        if (out_data.status !== due.status) begin
          err_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, due.status,
                   out_data.status);
        end
        if (out_data.consumed_length !== due.consumed_length) begin
          err_cnt++;
          $display("%0t: length expected %0d actual %0d", $time, due.consumed_length,
                   out_data.consumed_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    m_active = 1'b0;
    m_field  = '0;
    m_packed = '0;
    m_pos    = '0;
    clear_number();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_valid_fields();
    test_range_errors();
    test_missing_comma();
    test_fourth_terminator();
    test_restart_and_idle();
    test_long_position();
    test_random_records();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/datp_pkg.sv
hdl/datp_fifo.sv
hdl/datp_front.sv
hdl/datp_back.sv
hdl/decimal_argb_text_parser_unit.sv
verif/testbench.sv
